### rtl/pvst_pkg.sv
// ---------------------------------------------------------------------------
// Pump and valve safety timer: shared types and constants
// Beat payloads, command and register codes, state encoding and the timer
// helper functions used by the top level and the valve store.
// ---------------------------------------------------------------------------
package pvst_pkg;

	// Widest valve address over the supported range of valve counts (up to 64).
	localparam int ADDR_W = 6;
	// APB address width: three 32-bit registers at byte addresses 0, 4 and 8.
	localparam int PADDR_W = 4;
	localparam int EL_W = 27;
	localparam int LIM_W = 26;

	localparam logic [EL_W-1:0] ELAPSED_MAX = '1;
	localparam logic [LIM_W-1:0] MS_PER_S = LIM_W'(1000);
	localparam logic [4:0] VALVE_COUNT_RST = 5'd16;
	localparam logic [LIM_W-1:0] PUMP_MAX_RST = LIM_W'(60000);
	localparam logic [LIM_W-1:0] VALVE_MAX_RST = LIM_W'(30000);

	// Command codes carried in the mode field.
	localparam logic [2:0] MODE_TICK      = 3'd0;
	localparam logic [2:0] MODE_PUMP_ON   = 3'd1;
	localparam logic [2:0] MODE_PUMP_OFF  = 3'd2;
	localparam logic [2:0] MODE_OPEN      = 3'd3;
	localparam logic [2:0] MODE_CLOSE     = 3'd4;
	localparam logic [2:0] MODE_CLOSE_ALL = 3'd5;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_VALVE_COUNT = 2'd0;
	localparam logic [1:0] REG_PUMP_MAX    = 2'd1;
	localparam logic [1:0] REG_VALVE_MAX   = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  valve_sel;
		logic [15:0] duration_seconds;
	} cmd_t;

	typedef struct packed {
		logic        pump_running;
		logic [15:0] valve_open_mask;
		logic        request_ignored;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Request from the sequencer to the valve store.
	typedef struct packed {
		logic              wr_open;
		logic              rd_en;
		logic              rd_open;
		logic [ADDR_W-1:0] addr;
		logic [LIM_W-1:0]  limit_ms;
	} vreq_t;

	// Outcome of one timed valve entry.
	typedef struct packed {
		logic              valid;
		logic              shut;
		logic [ADDR_W-1:0] addr;
	} vrsp_t;

	// Elapsed counter plus one, holding at its ceiling.
	function automatic logic [EL_W-1:0] sat_inc(input logic [EL_W-1:0] el);
		sat_inc = (el == ELAPSED_MAX) ? el : el + EL_W'(1);
	endfunction

	// A unit expires at its own duration, when one is set, or at the maximum.
	function automatic logic timer_expired(input logic [EL_W-1:0] el,
		input logic [LIM_W-1:0] lim, input logic [LIM_W-1:0] mx);
		timer_expired = ((lim != '0) && (el >= {1'b0, lim})) || (el >= {1'b0, mx});
	endfunction

endpackage

### rtl/pump_valve_safety_timer.sv
// ---------------------------------------------------------------------------
// Pump and valve safety timer
// One pump and up to VALVES valves, each switched by command beats and shut
// by its own on-time limit or a configured maximum as millisecond ticks come.
// ---------------------------------------------------------------------------
// A command beat passes through the execute and completion states and then the output
// register; a tick, unless it shuts the pump or no valve is in use, also sweeps the
// valves in use and drains the store pipeline. Only one beat is in flight at a time: a
// new beat is taken in idle. The valve memory sweep reads one entry per cycle.
// A stalled output register holds the sequencer until the result is taken.
// Reset clears pump and flags, restores register defaults; memory needs no clearing.
module pump_valve_safety_timer #(
	parameter int VALVES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  pvst_pkg::cmd_t               cmd,
	output logic                         res_valid,
	input  logic                         res_ready,
	output pvst_pkg::res_t               res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pvst_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import pvst_pkg::*;

	localparam int AW = (VALVES > 1) ? $clog2(VALVES) : 1;
	localparam int CW = ($clog2(VALVES + 1) > 5) ? $clog2(VALVES + 1) : 5;
	localparam int MB = (VALVES < 16) ? VALVES : 16;

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [4:0]        valve_count_q;
	logic [LIM_W-1:0]  pump_max_q;
	logic [LIM_W-1:0]  valve_max_q;
	logic              pump_on_q;
	logic [EL_W-1:0]   pump_el_q;
	logic [LIM_W-1:0]  pump_lim_q;
	logic [VALVES-1:0] flags_q;
	logic [CW-1:0]     idx_q;
	logic              ign_q;
	res_t              res_q;
	logic              res_valid_q;

	logic [CW-1:0]     cnt;
	logic [ADDR_W-1:0] open_addr;
	logic              idx_ok;
	logic              open_ok;
	logic [LIM_W-1:0]  dur_ms;
	logic [EL_W-1:0]   pump_inc;
	logic              pump_exp;
	logic              res_free;
	logic              cfg_wr;
	logic [15:0]       mask;
	vreq_t             vreq;
	vrsp_t             vrsp;

	// Valve count in use and the checks on the addressed valve.
	always_comb begin
		cnt       = (CW'(valve_count_q) > CW'(VALVES)) ? CW'(VALVES) : CW'(valve_count_q);
		open_addr = ADDR_W'(cmd_q.valve_sel);
		idx_ok    = CW'(cmd_q.valve_sel) < cnt;
		open_ok   = idx_ok && pump_on_q && !flags_q[open_addr[AW-1:0]];
		dur_ms    = LIM_W'(cmd_q.duration_seconds) * MS_PER_S;
		pump_inc  = sat_inc(pump_el_q);
		pump_exp  = timer_expired(pump_inc, pump_lim_q, pump_max_q);
		res_free  = !res_valid_q || res_ready;
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd_q.mode == MODE_TICK && !(pump_on_q && pump_exp) && cnt != '0) begin
					state_d = ST_SWEEP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SWEEP: begin
				if (idx_q == cnt - CW'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: handshake and valve store requests.
	always_comb begin
		cmd_ready = 1'b0;
		vreq      = '{wr_open: 1'b0, rd_en: 1'b0, rd_open: 1'b0,
			addr: open_addr, limit_ms: dur_ms};
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
			end
			ST_EXEC: begin
				vreq.wr_open = (cmd_q.mode == MODE_OPEN) && open_ok;
			end
			ST_SWEEP: begin
				vreq.rd_en   = 1'b1;
				vreq.rd_open = flags_q[idx_q[AW-1:0]];
				vreq.addr    = ADDR_W'(idx_q);
			end
			ST_DRAIN, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command capture.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
	end

	// Pump and valve flag state, updated by commands, ticks and the sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_on_q  <= 1'b0;
			pump_el_q  <= '0;
			pump_lim_q <= '0;
			flags_q    <= '0;
			idx_q      <= '0;
			ign_q      <= 1'b0;
		end else begin
			if (state_q == ST_EXEC) begin
				ign_q <= ((cmd_q.mode == MODE_PUMP_ON) && pump_on_q)
					|| ((cmd_q.mode == MODE_OPEN) && !open_ok);
				idx_q <= '0;
				unique case (cmd_q.mode)
					MODE_TICK: begin
						if (pump_on_q && pump_exp) begin
							pump_on_q  <= 1'b0;
							pump_el_q  <= '0;
							pump_lim_q <= '0;
							for (int i = 0; i < VALVES; i++) begin
								if (CW'(i) < cnt) begin
									flags_q[i] <= 1'b0;
								end
							end
						end else if (pump_on_q) begin
							pump_el_q <= pump_inc;
						end
					end
					MODE_PUMP_ON: begin
						if (!pump_on_q) begin
							pump_on_q  <= 1'b1;
							pump_el_q  <= '0;
							pump_lim_q <= dur_ms;
						end
					end
					MODE_PUMP_OFF: begin
						pump_on_q  <= 1'b0;
						pump_el_q  <= '0;
						pump_lim_q <= '0;
						for (int i = 0; i < VALVES; i++) begin
							if (CW'(i) < cnt) begin
								flags_q[i] <= 1'b0;
							end
						end
					end
					MODE_OPEN: begin
						if (open_ok) begin
							flags_q[open_addr[AW-1:0]] <= 1'b1;
						end
					end
					MODE_CLOSE: begin
						if (idx_ok) begin
							flags_q[open_addr[AW-1:0]] <= 1'b0;
						end
					end
					MODE_CLOSE_ALL: begin
						for (int i = 0; i < VALVES; i++) begin
							if (CW'(i) < cnt) begin
								flags_q[i] <= 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_SWEEP) begin
				idx_q <= idx_q + CW'(1);
			end
			// A valve whose timer ran out in the store is shut.
			if (vrsp.valid && vrsp.shut) begin
				flags_q[vrsp.addr[AW-1:0]] <= 1'b0;
			end
		end
	end

	// Mask of the valves that fit the result field.
	always_comb begin
		mask = '0;
		for (int i = 0; i < MB; i++) begin
			mask[i] = flags_q[i];
		end
	end

	// Output register: parts the result from the command side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && res_free) begin
			res_q <= '{pump_running: pump_on_q, valve_open_mask: mask,
				request_ignored: ign_q};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Configuration registers.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_count_q <= VALVE_COUNT_RST;
			pump_max_q    <= PUMP_MAX_RST;
			valve_max_q   <= VALVE_MAX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_VALVE_COUNT: valve_count_q <= pwdata[4:0];
				REG_PUMP_MAX:    pump_max_q    <= pwdata[LIM_W-1:0];
				REG_VALVE_MAX:   valve_max_q   <= pwdata[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_VALVE_COUNT: prdata = 32'(valve_count_q);
			REG_PUMP_MAX:    prdata = 32'(pump_max_q);
			REG_VALVE_MAX:   prdata = 32'(valve_max_q);
			default:         prdata = '0;
		endcase
	end

	pvst_valve_store #(
		.VALVES(VALVES)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (vreq),
		.valve_max_ms(valve_max_q),
		.rsp         (vrsp)
	);

	// An accepted beat is executed in the following cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> state_q == ST_EXEC)
		else $error("accepted beat not executed");

	// The sweep stays within the valve count in use.
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> idx_q < cnt)
		else $error("sweep index beyond the valve count");

	// A result only appears from the completion state.
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");

	// Store results only come while the sweep runs or drains.
	a_rsp_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		vrsp.valid |-> state_q == ST_SWEEP || state_q == ST_DRAIN)
		else $error("valve result outside the sweep");

endmodule

### rtl/pvst_valve_store.sv
// ---------------------------------------------------------------------------
// Valve timer store
// Holds the elapsed and limit fields of every valve in one synchronous
// memory, and times one open entry a cycle in a read-modify-write pipeline.
// ---------------------------------------------------------------------------
module pvst_valve_store #(
	parameter int VALVES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pvst_pkg::vreq_t           req,
	input  logic [pvst_pkg::LIM_W-1:0] valve_max_ms,
	output pvst_pkg::vrsp_t           rsp
);
	import pvst_pkg::*;

	localparam int AW = (VALVES > 1) ? $clog2(VALVES) : 1;

	typedef struct packed {
		logic [EL_W-1:0]  elapsed;
		logic [LIM_W-1:0] limit;
	} entry_t;

	entry_t            mem [VALVES];
	entry_t            data_s1;
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [EL_W-1:0]   inc;
	logic              shut;

	// Read port: the data is registered.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			data_s1 <= mem[req.addr[AW-1:0]];
		end
		addr_s1 <= req.addr;
	end

	// Only entries of open valves are timed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.rd_en && req.rd_open;
		end
	end

	// Advance the counter of the entry read in the previous cycle.
	always_comb begin
		inc  = sat_inc(data_s1.elapsed);
		shut = timer_expired(inc, data_s1.limit, valve_max_ms);
	end

	// Write port: a valve being opened, or the write-back of a timed entry.
	always_ff @(posedge clk) begin
		if (req.wr_open) begin
			mem[req.addr[AW-1:0]] <= '{elapsed: '0, limit: req.limit_ms};
		end else if (valid_s1 && !shut) begin
			mem[addr_s1[AW-1:0]] <= '{elapsed: inc, limit: data_s1.limit};
		end
	end

	assign rsp = '{valid: valid_s1, shut: shut, addr: addr_s1};

	// An opening never coincides with the sweep.
	a_open_not_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_open |-> !req.rd_en && !valid_s1)
		else $error("valve opened while the sweep was running");

	// Every result follows a read of an open entry in the previous cycle.
	a_rsp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(req.rd_en && req.rd_open))
		else $error("valve result without a matching read");

	// Consecutive results address different entries.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && $past(valid_s1) |-> addr_s1 != $past(addr_s1))
		else $error("same valve entry timed in back-to-back cycles");

endmodule
